FILE: hw/rtl/ogcc_pkg.sv
// ogcc_pkg: shared types, register indexes and helpers for the occupancy grid
// collision checker. Used by every module under hw/rtl.
package ogcc_pkg;

  localparam int GRID_X_MAX_DEF = 256;
  localparam int GRID_Y_MAX_DEF = 256;
  localparam int MAX_STEPS_DEF  = 1024;

  localparam int APB_ADDR_W = 5;
  localparam int QUEUE_DEPTH = 2;

  // quotient and divisor widths of the slope divider
  localparam int DIV_NUM_W = 63;
  localparam int DIV_DEN_W = 33;

  localparam logic [1:0] OP_MARK    = 2'd0;
  localparam logic [1:0] OP_POINT   = 2'd1;
  localparam logic [1:0] OP_SEGMENT = 2'd2;
  localparam logic [1:0] OP_SNAP    = 2'd3;

  localparam logic [2:0] REG_ORIGIN_X  = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y  = 3'd1;
  localparam logic [2:0] REG_LIMIT_X   = 3'd2;
  localparam logic [2:0] REG_LIMIT_Y   = 3'd3;
  localparam logic [2:0] REG_CELL_SIZE = 3'd4;
  localparam logic [2:0] REG_CELL_RCP  = 3'd5;
  localparam logic [2:0] REG_CELLS_X   = 3'd6;
  localparam logic [2:0] REG_CELLS_Y   = 3'd7;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [31:0] x1;
    logic signed [31:0] y1;
    logic signed [31:0] x2;
    logic signed [31:0] y2;
  } cmd_t;

  typedef struct packed {
    logic               is_free;
    logic               step_cap_hit;
    logic signed [31:0] snapped_x;
    logic signed [31:0] snapped_y;
  } res_t;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] limit_x;
    logic signed [31:0] limit_y;
    logic [30:0]        cell_size;
    logic [30:0]        cell_size_recip;
    logic [8:0]         cells_x;
    logic [8:0]         cells_y;
  } cfg_t;

  // back to front: queue pop and clear-pass status
  typedef struct packed {
    logic pop;
    logic clearing;
  } bk_ctl_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] numer;
    logic [DIV_DEN_W-1:0] denom;
  } div_req_t;

  typedef struct packed {
    logic                 busy;
    logic                 valid;
    logic [DIV_NUM_W-1:0] quot;
  } div_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [65:0] lo;
    logic signed [65:0] hi;
    lo = -66'sd2147483648;
    hi = 66'sd2147483647;
    if (v < lo) begin
      sat32 = 32'sh8000_0000;
    end else if (v > hi) begin
      sat32 = 32'sh7fff_ffff;
    end else begin
      sat32 = 32'(v);
    end
  endfunction

endpackage

FILE: hw/rtl/ogcc_front.sv
// ogcc_front: command intake and the short queue ahead of the executor.
// Depends on ogcc_pkg.
module ogcc_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  ogcc_pkg::cmd_t  cmd,
  output logic            busy,
  input  ogcc_pkg::bk_ctl_t bk,
  output logic            q_valid,
  output ogcc_pkg::cmd_t  q_head
);
  import ogcc_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          entry [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          accept;
  logic          pop;

  assign busy    = (count == CW'(QUEUE_DEPTH)) || bk.clearing;
  assign accept  = start && !busy;
  assign q_valid = (count != '0);
  assign q_head  = entry[rd_ptr];
  assign pop     = bk.pop && q_valid;

  always_ff @(posedge clk) begin
    if (accept) begin
      entry[wr_ptr] <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (accept) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({accept, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: hw/rtl/ogcc_div.sv
// ogcc_div: restoring unsigned divider, one quotient bit per cycle, for the
// segment slope. Depends on ogcc_pkg.
module ogcc_div (
  input  logic               clk,
  input  logic               rst,
  input  ogcc_pkg::div_req_t req,
  output ogcc_pkg::div_rsp_t rsp
);
  import ogcc_pkg::*;

  localparam int CNT_W = $clog2(DIV_NUM_W);

  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] den;
  logic [DIV_NUM_W-1:0] quo;
  logic [CNT_W-1:0]     cnt;
  logic                 busy;
  logic                 valid;
  logic [DIV_DEN_W:0]   trial;
  logic                 fits;

  assign trial = {rem, quo[DIV_NUM_W-1]};
  assign fits  = (trial >= {1'b0, den});

  assign rsp.busy  = busy;
  assign rsp.valid = valid;
  assign rsp.quot  = quo;

  always_ff @(posedge clk) begin
    if (req.start && !busy) begin
      rem <= '0;
      den <= req.denom;
      quo <= req.numer;
    end else if (busy) begin
      rem <= fits ? DIV_DEN_W'(trial - {1'b0, den}) : DIV_DEN_W'(trial);
      quo <= {quo[DIV_NUM_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      valid <= 1'b0;
      cnt   <= '0;
    end else begin
      valid <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == CNT_W'(DIV_NUM_W - 1)) begin
          busy  <= 1'b0;
          valid <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

endmodule

FILE: hw/rtl/ogcc_back.sv
// ogcc_back: executor with the occupancy memory, a shared multiplier and the
// segment walker. Depends on ogcc_pkg and ogcc_div.
module ogcc_back #(
  parameter int GRID_X_MAX = ogcc_pkg::GRID_X_MAX_DEF,
  parameter int GRID_Y_MAX = ogcc_pkg::GRID_Y_MAX_DEF,
  parameter int MAX_STEPS  = ogcc_pkg::MAX_STEPS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  ogcc_pkg::cfg_t    cfg,
  input  logic              q_valid,
  input  ogcc_pkg::cmd_t    q_head,
  output ogcc_pkg::bk_ctl_t bk,
  output logic              done,
  output ogcc_pkg::res_t    result
);
  import ogcc_pkg::*;

  localparam int DEPTH = GRID_X_MAX * GRID_Y_MAX;
  localparam int AW    = $clog2(DEPTH);
  localparam int XW    = $clog2(GRID_X_MAX);
  localparam int YW    = $clog2(GRID_Y_MAX);
  localparam int CXW   = $clog2(GRID_X_MAX + 1);
  localparam int CYW   = $clog2(GRID_Y_MAX + 1);
  localparam int SW    = $clog2(MAX_STEPS + 1);

  localparam logic signed [36:0] OFF_LIM  = 37'sd8589934592;
  localparam logic [DIV_NUM_W-1:0] STEP_LIM = DIV_NUM_W'(64'd17179869184);

  typedef enum logic [21:0] {
    S_CLEAR = 22'b0000000000000000000001,
    S_IDLE  = 22'b0000000000000000000010,
    S_LOAD  = 22'b0000000000000000000100,
    S_DIVL  = 22'b0000000000000000001000,
    S_DIVW  = 22'b0000000000000000010000,
    S_DIST  = 22'b0000000000000000100000,
    S_SQX   = 22'b0000000000000001000000,
    S_SQY   = 22'b0000000000000010000000,
    S_SQC   = 22'b0000000000000100000000,
    S_CMP   = 22'b0000000000001000000000,
    S_STEP  = 22'b0000000000010000000000,
    S_MOVE  = 22'b0000000000100000000000,
    S_QX    = 22'b0000000001000000000000,
    S_QY    = 22'b0000000010000000000000,
    S_IDX   = 22'b0000000100000000000000,
    S_POS   = 22'b0000001000000000000000,
    S_ACC   = 22'b0000010000000000000000,
    S_USE   = 22'b0000100000000000000000,
    S_SNX   = 22'b0001000000000000000000,
    S_SNY   = 22'b0010000000000000000000,
    S_SNO   = 22'b0100000000000000000000,
    S_SPARE = 22'b1000000000000000000000
  } state_t;

  state_t state;

  cmd_t               cur;
  logic signed [31:0] tx;
  logic signed [31:0] ty;
  logic signed [34:0] offx;
  logic signed [34:0] offy;
  logic signed [31:0] stx;
  logic signed [35:0] sty;
  logic [SW-1:0]      steps;
  logic [32:0]        adx;
  logic               p_neg;
  logic [32:0]        ax;
  logic [32:0]        ay;
  logic [63:0]        sq;
  logic signed [65:0] qx;
  logic [XW-1:0]      ix;
  logic [YW-1:0]      iy;
  logic               mark_ok;
  logic signed [31:0] sx;
  logic [AW-1:0]      clr_cnt;

  logic signed [33:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [65:0] prod;

  logic               mem [DEPTH];
  logic               mem_we;
  logic               mem_wdata;
  logic [AW-1:0]      mem_addr;
  logic               rd_bit;

  div_req_t           div_req;
  div_rsp_t           div_rsp;

  logic [CXW-1:0]     cx_eff;
  logic [CYW-1:0]     cy_eff;
  logic signed [31:0] cs;
  logic signed [32:0] dx_w;
  logic signed [32:0] dy_w;
  logic signed [33:0] ddx;
  logic signed [33:0] ddy;
  logic [32:0]        ax_w;
  logic [32:0]        ay_w;
  logic signed [65:0] prod_abs;
  logic signed [65:0] qx_abs;
  logic signed [65:0] qy_abs;
  logic [31:0]        mag_x;
  logic [31:0]        mag_y;
  logic [XW-1:0]      ix_w;
  logic [YW-1:0]      iy_w;
  logic               ok_w;
  logic signed [36:0] sumx;
  logic signed [36:0] sumy;
  logic [DIV_NUM_W-1:0] qclip;
  logic signed [65:0] half;

  ogcc_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // cell counts limited to 1..grid size
  always_comb begin
    if (cfg.cells_x == '0) begin
      cx_eff = CXW'(1);
    end else if (32'(cfg.cells_x) > 32'(GRID_X_MAX)) begin
      cx_eff = CXW'(GRID_X_MAX);
    end else begin
      cx_eff = CXW'(cfg.cells_x);
    end
    if (cfg.cells_y == '0) begin
      cy_eff = CYW'(1);
    end else if (32'(cfg.cells_y) > 32'(GRID_Y_MAX)) begin
      cy_eff = CYW'(GRID_Y_MAX);
    end else begin
      cy_eff = CYW'(cfg.cells_y);
    end
  end

  assign cs   = signed'({1'b0, cfg.cell_size});
  assign half = 66'(signed'({2'b00, cfg.cell_size[30:1]}));
  assign dx_w = 33'(cur.x2) - 33'(cur.x1);
  assign dy_w = 33'(cur.y2) - 33'(cur.y1);
  assign ddx  = 34'(tx) - 34'(cur.x2);
  assign ddy  = 34'(ty) - 34'(cur.y2);
  assign ax_w = ddx[33] ? 33'(-ddx) : 33'(ddx);
  assign ay_w = ddy[33] ? 33'(-ddy) : 33'(ddy);
  assign prod_abs = prod[65] ? -prod : prod;
  assign sumx = 37'(offx) + 37'(stx);
  assign sumy = 37'(offy) + 37'(sty);
  assign qclip = (div_rsp.quot > STEP_LIM) ? STEP_LIM : div_rsp.quot;

  // index from the truncated Q32.32 products, clamped to the grid
  always_comb begin
    qx_abs = qx[65] ? -qx : qx;
    qy_abs = prod[65] ? -prod : prod;
    mag_x  = qx_abs[63:32];
    mag_y  = qy_abs[63:32];
    if (qx[65]) begin
      ix_w = '0;
    end else if (mag_x >= 32'(cx_eff)) begin
      ix_w = XW'(cx_eff - 1'b1);
    end else begin
      ix_w = XW'(mag_x);
    end
    if (prod[65]) begin
      iy_w = '0;
    end else if (mag_y >= 32'(cy_eff)) begin
      iy_w = YW'(cy_eff - 1'b1);
    end else begin
      iy_w = YW'(mag_y);
    end
    ok_w = (tx >= cfg.origin_x) && (ty >= cfg.origin_y) &&
           (tx < cfg.limit_x) && (ty < cfg.limit_y) &&
           ((mag_x == '0) || (!qx[65] && (mag_x < 32'(cx_eff)))) &&
           ((mag_y == '0) || (!prod[65] && (mag_y < 32'(cy_eff))));
  end

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_QX: begin
        mul_a = 34'(tx) - 34'(cfg.origin_x);
        mul_b = signed'({1'b0, cfg.cell_size_recip});
      end
      S_QY: begin
        mul_a = 34'(ty) - 34'(cfg.origin_y);
        mul_b = signed'({1'b0, cfg.cell_size_recip});
      end
      S_POS: begin
        mul_a = signed'(34'(ix));
        mul_b = signed'(32'(cy_eff));
      end
      S_SNX: begin
        mul_a = signed'(34'(ix));
        mul_b = cs;
      end
      S_SNY: begin
        mul_a = signed'(34'(iy));
        mul_b = cs;
      end
      S_LOAD: begin
        mul_a = 34'(dy_w);
        mul_b = cs;
      end
      S_SQX: begin
        mul_a = signed'(34'(ax));
        mul_b = signed'(32'(ax));
      end
      S_SQY: begin
        mul_a = signed'(34'(ay));
        mul_b = signed'(32'(ay));
      end
      S_SQC: begin
        mul_a = 34'(cs);
        mul_b = cs;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= 66'(mul_a) * 66'(mul_b);
  end

  // memory port: clear pass, mark write, lookups
  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = 1'b0;
    mem_addr  = prod[AW-1:0] + AW'(iy);
    if (state == S_CLEAR) begin
      mem_we   = 1'b1;
      mem_addr = clr_cnt;
    end else if (state == S_ACC && cur.operation == OP_MARK) begin
      mem_we    = mark_ok;
      mem_wdata = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rd_bit <= mem[mem_addr];
  end

  assign div_req.start = (state == S_DIVL);
  assign div_req.numer = prod_abs[DIV_NUM_W-1:0];
  assign div_req.denom = adx;

  assign bk.pop      = (state == S_IDLE) && q_valid;
  assign bk.clearing = (state == S_CLEAR);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          if (clr_cnt == AW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end else begin
            clr_cnt <= clr_cnt + 1'b1;
          end
        end
        S_IDLE: begin
          if (q_valid) begin
            state <= (q_head.operation == OP_SEGMENT) ? S_LOAD : S_QX;
          end
        end
        S_LOAD: begin
          if (dx_w != '0) begin
            state <= S_DIVL;
          end else begin
            state <= S_DIST;
          end
        end
        S_DIVL: state <= S_DIVW;
        S_DIVW: begin
          if (div_rsp.valid) begin
            state <= S_DIST;
          end
        end
        S_DIST: begin
          if ((ax_w > 33'(cfg.cell_size)) || (ay_w > 33'(cfg.cell_size))) begin
            state <= S_STEP;
          end else begin
            state <= S_SQX;
          end
        end
        S_SQX: state <= S_SQY;
        S_SQY: state <= S_SQC;
        S_SQC: state <= S_CMP;
        S_CMP: begin
          if (66'(sq) > prod) begin
            state <= S_STEP;
          end else begin
            done           <= 1'b1;
            result         <= '{is_free: 1'b1, step_cap_hit: 1'b0,
                                snapped_x: '0, snapped_y: '0};
            state          <= S_IDLE;
          end
        end
        S_STEP: begin
          if (steps >= SW'(MAX_STEPS)) begin
            done   <= 1'b1;
            result <= '{is_free: 1'b1, step_cap_hit: 1'b1,
                        snapped_x: '0, snapped_y: '0};
            state  <= S_IDLE;
          end else begin
            state <= S_MOVE;
          end
        end
        S_MOVE: state <= S_QX;
        S_QX:   state <= S_QY;
        S_QY:   state <= S_IDX;
        S_IDX:  state <= (cur.operation == OP_SNAP) ? S_SNX : S_POS;
        S_POS:  state <= S_ACC;
        S_ACC:  state <= (cur.operation == OP_MARK) ? S_IDLE : S_USE;
        S_USE: begin
          if (cur.operation == OP_POINT) begin
            done   <= 1'b1;
            result <= '{is_free: !rd_bit, step_cap_hit: 1'b0,
                        snapped_x: '0, snapped_y: '0};
            state  <= S_IDLE;
          end else if (rd_bit) begin
            done   <= 1'b1;
            result <= '{is_free: 1'b0, step_cap_hit: 1'b0,
                        snapped_x: '0, snapped_y: '0};
            state  <= S_IDLE;
          end else begin
            state <= S_DIST;
          end
        end
        S_SNX: state <= S_SNY;
        S_SNY: state <= S_SNO;
        S_SNO: begin
          done   <= 1'b1;
          result <= '{is_free: 1'b0, step_cap_hit: 1'b0, snapped_x: sx,
                      snapped_y: sat32(prod + half + 66'(cfg.origin_y))};
          state  <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (q_valid) begin
          cur   <= q_head;
          tx    <= q_head.x1;
          ty    <= q_head.y1;
          offx  <= '0;
          offy  <= '0;
          steps <= '0;
        end
      end
      S_LOAD: begin
        adx <= dx_w[32] ? 33'(-dx_w) : 33'(dx_w);
        if (dx_w != '0) begin
          stx <= dx_w[32] ? -cs : cs;
        end else begin
          stx <= '0;
          if (dy_w[32]) begin
            sty <= -36'(cs);
          end else if (dy_w != '0) begin
            sty <= 36'(cs);
          end else begin
            sty <= '0;
          end
        end
      end
      S_DIVL: p_neg <= prod[65];
      S_DIVW: begin
        if (div_rsp.valid) begin
          sty <= p_neg ? -signed'(36'(qclip)) : signed'(36'(qclip));
        end
      end
      S_DIST: begin
        ax <= ax_w;
        ay <= ay_w;
      end
      S_SQY: sq <= prod[63:0];
      S_SQC: sq <= sq + prod[63:0];
      S_STEP: begin
        if (steps < SW'(MAX_STEPS)) begin
          steps <= steps + 1'b1;
          offx  <= (sumx > OFF_LIM) ? 35'(OFF_LIM) :
                   (sumx < -OFF_LIM) ? 35'(-OFF_LIM) : 35'(sumx);
          offy  <= (sumy > OFF_LIM) ? 35'(OFF_LIM) :
                   (sumy < -OFF_LIM) ? 35'(-OFF_LIM) : 35'(sumy);
        end
      end
      S_MOVE: begin
        tx <= sat32(66'(cur.x1) + 66'(offx));
        ty <= sat32(66'(cur.y1) + 66'(offy));
      end
      S_QY: qx <= prod;
      S_IDX: begin
        ix      <= ix_w;
        iy      <= iy_w;
        mark_ok <= ok_w;
      end
      S_SNY: sx <= sat32(prod + half + 66'(cfg.origin_x));
      default: begin
      end
    endcase
  end

  ap_mem_write_is_mark: assert property (@(posedge clk) disable iff (rst)
    (mem_we && (state != S_CLEAR)) |-> (cur.operation == OP_MARK))
    else $error("grid written outside a mark");

  ap_no_result_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !done)
    else $error("result during clear pass");

  ap_steps_bounded: assert property (@(posedge clk) disable iff (rst)
    steps <= SW'(MAX_STEPS))
    else $error("walk step count past cap");

  ap_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("divider restarted while busy");

  ap_single_result: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("two results in a row");

endmodule

FILE: hw/rtl/occupancy_grid_collision_checker.sv
// occupancy_grid_collision_checker: top level with the register port, the
// command front end and the executor. Depends on ogcc_pkg, ogcc_front, ogcc_back.
//
// Usage: a command (operation, x1, y1, x2, y2, all Q16.16) is taken when start
// is high and busy is low. Mark writes one grid cell and gives no result;
// point query, segment query and snap each give one result on result, valid
// for the single cycle that done is high. The receiver cannot stall results.
// A two-entry queue holds commands while the executor works on one at a time.
// A segment query first sets up the slope in the slope divider (one bit a
// cycle; the divider is skipped for a vertical segment), then walks cell by
// cell, with a squared distance check when the coarse distance test is not
// decisive, up to MAX_STEPS cells, and ends with the final distance check.
// After reset the grid memory is cleared one cell a cycle, all GRID_X_MAX *
// GRID_Y_MAX cells (65536 by default); busy stays high until it is done.
// Registers are written over the APB port at byte address 4*index and read
// back there; write them only while no command is in flight.
module occupancy_grid_collision_checker #(
  parameter int GRID_X_MAX = ogcc_pkg::GRID_X_MAX_DEF,
  parameter int GRID_Y_MAX = ogcc_pkg::GRID_Y_MAX_DEF,
  parameter int MAX_STEPS  = ogcc_pkg::MAX_STEPS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  ogcc_pkg::cmd_t                  cmd,
  output logic                            busy,
  output logic                            done,
  output ogcc_pkg::res_t                  result,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ogcc_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import ogcc_pkg::*;

  cfg_t    cfg;
  bk_ctl_t bk;
  logic    q_valid;
  cmd_t    q_head;
  logic    wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[APB_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.origin_x        <= '0;
      cfg.origin_y        <= '0;
      cfg.limit_x         <= 32'sd16777216;
      cfg.limit_y         <= 32'sd16777216;
      cfg.cell_size       <= 31'd65536;
      cfg.cell_size_recip <= 31'd65536;
      cfg.cells_x         <= 9'd256;
      cfg.cells_y         <= 9'd256;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_ORIGIN_X:  cfg.origin_x        <= pwdata;
        REG_ORIGIN_Y:  cfg.origin_y        <= pwdata;
        REG_LIMIT_X:   cfg.limit_x         <= pwdata;
        REG_LIMIT_Y:   cfg.limit_y         <= pwdata;
        REG_CELL_SIZE: cfg.cell_size       <= pwdata[30:0];
        REG_CELL_RCP:  cfg.cell_size_recip <= pwdata[30:0];
        REG_CELLS_X:   cfg.cells_x         <= pwdata[8:0];
        REG_CELLS_Y:   cfg.cells_y         <= pwdata[8:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ORIGIN_X:  prdata = cfg.origin_x;
      REG_ORIGIN_Y:  prdata = cfg.origin_y;
      REG_LIMIT_X:   prdata = cfg.limit_x;
      REG_LIMIT_Y:   prdata = cfg.limit_y;
      REG_CELL_SIZE: prdata = {1'b0, cfg.cell_size};
      REG_CELL_RCP:  prdata = {1'b0, cfg.cell_size_recip};
      REG_CELLS_X:   prdata = {23'd0, cfg.cells_x};
      REG_CELLS_Y:   prdata = {23'd0, cfg.cells_y};
      default:       prdata = '0;
    endcase
  end

  ogcc_front u_front (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .cmd     (cmd),
    .busy    (busy),
    .bk      (bk),
    .q_valid (q_valid),
    .q_head  (q_head)
  );

  ogcc_back #(
    .GRID_X_MAX (GRID_X_MAX),
    .GRID_Y_MAX (GRID_Y_MAX),
    .MAX_STEPS  (MAX_STEPS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_head  (q_head),
    .bk      (bk),
    .done    (done),
    .result  (result)
  );

endmodule
